>>> hdl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// Types, op codes and helpers for the 8-bit accumulator ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PAIR_W = 16;
    localparam int unsigned REQ_W  = 64;
    localparam int unsigned RES_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 5'd0,
        OP_ADC    = 5'd1,
        OP_SUB    = 5'd2,
        OP_SBB    = 5'd3,
        OP_ANA    = 5'd4,
        OP_XRA    = 5'd5,
        OP_ORA    = 5'd6,
        OP_CMP    = 5'd7,
        OP_RLC    = 5'd8,
        OP_RRC    = 5'd9,
        OP_RAL    = 5'd10,
        OP_RAR    = 5'd11,
        OP_CMA    = 5'd12,
        OP_CMC    = 5'd13,
        OP_STC    = 5'd14,
        OP_INR    = 5'd15,
        OP_DCR    = 5'd16,
        OP_DAD    = 5'd17,
        OP_INX    = 5'd18,
        OP_DCX    = 5'd19,
        OP_PACK   = 5'd20,
        OP_UNPACK = 5'd21
    } t_op;

    // psw bit positions
    localparam int unsigned PSW_CY = 0;
    localparam int unsigned PSW_P  = 2;
    localparam int unsigned PSW_AC = 4;
    localparam int unsigned PSW_Z  = 6;
    localparam int unsigned PSW_S  = 7;

    typedef struct packed {
        logic              cy;
        logic              ac;
        logic              z;
        logic              s;
        logic              p;
    } t_flags;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] operand;
        logic [PAIR_W-1:0] pair_hl;
        logic [PAIR_W-1:0] pair_other;
        t_flags            flags;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [PAIR_W-1:0] pair_result;
        t_flags            flags;
        logic              writes_acc;
    } t_res;

    function automatic logic even_parity(input logic [BYTE_W-1:0] v);
        return ~(^v);
    endfunction

endpackage

>>> hdl/eight_bit_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core
// Accumulator ALU and flag unit of an 8080-style processor.
// ----------------------------------------------------------------------------
// One request goes in, one result comes out. The block holds an input
// register and a result register with a single pass of adder, logic and
// rotate decode between them, so it takes a new request every cycle when
// the output is not stalled. The result register holds each result until
// it is taken. Both stages keep moving while the downstream side stalls only
// if a stage is empty. No state is kept between requests.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core
    import alu8f_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // op[4:0], acc[12:5], operand[20:13], pair_hl[36:21], pair_other[52:37],
    // carry_in[53], aux_in[54], zero_in[55], sign_in[56], parity_in[57], zero fill
    input  logic [REQ_W-1:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // result_byte[7:0], pair_result[23:8], carry_out[24], aux_out[25],
    // zero_out[26], sign_out[27], parity_out[28], writes_acc[29], zero fill
    output logic [RES_W-1:0] o_m_axis_tdata
);

    t_req r_in;
    logic r_in_vld;
    t_res r_out;
    logic r_out_vld;
    t_res n_out;
    t_req req_in;
    logic out_ready;

    assign req_in.op         = i_s_axis_tdata[4:0];
    assign req_in.acc        = i_s_axis_tdata[12:5];
    assign req_in.operand    = i_s_axis_tdata[20:13];
    assign req_in.pair_hl    = i_s_axis_tdata[36:21];
    assign req_in.pair_other = i_s_axis_tdata[52:37];
    assign req_in.flags.cy   = i_s_axis_tdata[53];
    assign req_in.flags.ac   = i_s_axis_tdata[54];
    assign req_in.flags.z    = i_s_axis_tdata[55];
    assign req_in.flags.s    = i_s_axis_tdata[56];
    assign req_in.flags.p    = i_s_axis_tdata[57];

    assign out_ready       = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= req_in;
        end
        if (out_ready && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // datapath
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] add_b;
    logic              add_cin;
    logic [BYTE_W:0]   add_sum;
    logic [4:0]        add_nib;
    logic [PAIR_W:0]   dad_sum;
    logic [BYTE_W-1:0] res;
    t_flags            f;
    logic              set_szp;

    assign a = r_in.acc;
    assign b = r_in.operand;

    always_comb begin
        add_b   = b;
        add_cin = 1'b0;
        unique case (r_in.op)
            OP_ADC:         add_cin = r_in.flags.cy;
            OP_SUB, OP_CMP: begin
                add_b   = ~b;
                add_cin = 1'b1;
            end
            OP_SBB: begin
                add_b   = ~b;
                add_cin = ~r_in.flags.cy;
            end
            default: begin
                add_b   = b;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, a} + {1'b0, add_b} + {{BYTE_W{1'b0}}, add_cin};
    assign add_nib = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
    assign dad_sum = {1'b0, r_in.pair_hl} + {1'b0, r_in.pair_other};

    always_comb begin
        res                = a;
        f                  = r_in.flags;
        set_szp            = 1'b0;
        n_out.pair_result  = '0;
        n_out.writes_acc   = 1'b0;
        unique case (r_in.op)
            OP_ADD, OP_ADC: begin
                res              = add_sum[BYTE_W-1:0];
                f.cy             = add_sum[BYTE_W];
                f.ac             = add_nib[4];
                set_szp          = 1'b1;
                n_out.writes_acc = 1'b1;
            end
            OP_SUB, OP_SBB, OP_CMP: begin
                res              = add_sum[BYTE_W-1:0];
                f.cy             = ~add_sum[BYTE_W];
                f.ac             = add_nib[4];
                set_szp          = 1'b1;
                n_out.writes_acc = (r_in.op != OP_CMP);
            end
            OP_ANA: begin
                res              = a & b;
                f.cy             = 1'b0;
                f.ac             = a[3] | b[3];
                set_szp          = 1'b1;
                n_out.writes_acc = 1'b1;
            end
            OP_XRA, OP_ORA: begin
                res              = (r_in.op == OP_XRA) ? (a ^ b) : (a | b);
                f.cy             = 1'b0;
                f.ac             = 1'b0;
                set_szp          = 1'b1;
                n_out.writes_acc = 1'b1;
            end
            OP_RLC: begin
                res              = {a[6:0], a[7]};
                f.cy             = a[7];
                n_out.writes_acc = 1'b1;
            end
            OP_RRC: begin
                res              = {a[0], a[7:1]};
                f.cy             = a[0];
                n_out.writes_acc = 1'b1;
            end
            OP_RAL: begin
                res              = {a[6:0], r_in.flags.cy};
                f.cy             = a[7];
                n_out.writes_acc = 1'b1;
            end
            OP_RAR: begin
                res              = {r_in.flags.cy, a[7:1]};
                f.cy             = a[0];
                n_out.writes_acc = 1'b1;
            end
            OP_CMA: begin
                res              = ~a;
                n_out.writes_acc = 1'b1;
            end
            OP_CMC: f.cy = ~r_in.flags.cy;
            OP_STC: f.cy = 1'b1;
            OP_INR: begin
                res     = b + 8'd1;
                f.ac    = (b[3:0] == 4'hf);
                set_szp = 1'b1;
            end
            OP_DCR: begin
                res     = b - 8'd1;
                f.ac    = (b[3:0] != 4'h0);
                set_szp = 1'b1;
            end
            OP_DAD: begin
                f.cy              = dad_sum[PAIR_W];
                n_out.pair_result = dad_sum[PAIR_W-1:0];
            end
            OP_INX: n_out.pair_result = r_in.pair_other + 16'd1;
            OP_DCX: n_out.pair_result = r_in.pair_other - 16'd1;
            OP_PACK: begin
                res         = 8'h02;
                res[PSW_S]  = r_in.flags.s;
                res[PSW_Z]  = r_in.flags.z;
                res[PSW_AC] = r_in.flags.ac;
                res[PSW_P]  = r_in.flags.p;
                res[PSW_CY] = r_in.flags.cy;
            end
            OP_UNPACK: begin
                f.cy = b[PSW_CY];
                f.p  = b[PSW_P];
                f.ac = b[PSW_AC];
                f.z  = b[PSW_Z];
                f.s  = b[PSW_S];
            end
            default: begin
                res = a;
            end
        endcase
        if (set_szp) begin
            f.z = (res == '0);
            f.s = res[BYTE_W-1];
            f.p = even_parity(res);
        end
        n_out.result_byte = res;
        n_out.flags       = f;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out.writes_acc, r_out.flags.p, r_out.flags.s,
                              r_out.flags.z, r_out.flags.ac, r_out.flags.cy,
                              r_out.pair_result, r_out.result_byte};

endmodule
